// ===== hw/rtl/assert_macros.svh =====
// assertion helpers, included by the top-level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked on every clk edge, quiet while rst is high
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// checked on every clk edge, reset included
`define ASSERT_CLK_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== hw/rtl/strag_pkg.sv =====
// ----------------------------------------------------------------------------
// strag_pkg
// Types, codes and helper functions of the stencil tile read address generator.
// ----------------------------------------------------------------------------
package strag_pkg;

  localparam int unsigned NUM_TERMS   = 81;
  localparam int unsigned NUM_OFFS    = 27;
  localparam int unsigned CENTRE_OFF  = 39 / 3;
  localparam int unsigned PLANE_WORDS = 8192 / 4;
  localparam int unsigned PLANE_SHIFT = $clog2(PLANE_WORDS);

  localparam int unsigned PAGE_W = 24;
  localparam int unsigned HALO_W = 20;
  localparam int unsigned DEST_W = 5;
  localparam int unsigned BATCH_W = 5;
  localparam int unsigned GSLOT_W = 4;
  localparam int unsigned CFG_W = 16;
  localparam int unsigned CFG_IDX_W = 1;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_TERM_ORDER = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_BASE_GROUP = 1'b1;

  // order modes
  localparam logic [1:0] MODE_CENTRE = 2'd1;
  localparam logic [1:0] MODE_REV    = 2'd2;

  // descriptor kinds
  localparam logic KIND_A = 1'b0;
  localparam logic KIND_B = 1'b1;

  typedef struct packed {
    logic       load;
    logic       calc_grp;
    logic       calc_base;
    logic       emit;
    logic       sel_b;
    logic       corner_mode;
    logic [1:0] lane;
    logic [1:0] outer;
    logic [1:0] inner;
    logic       last;
  } cmd_t;

  typedef struct packed {
    logic corner;
  } status_t;

  typedef struct packed {
    logic [1:0] di;
    logic [1:0] dj;
    logic [1:0] dk;
  } digits_t;

  typedef struct packed {
    logic [1:0] in_c;
    logic [1:0] out_c;
  } rep_comp_t;

  // base-3 digits of a stencil offset 0..26
  function automatic digits_t off_digits(input logic [4:0] off);
    digits_t    d;
    logic [4:0] r;
    r = off;
    if (r >= 5'd18) begin
      d.di = 2'd2;
      r = r - 5'd18;
    end else if (r >= 5'd9) begin
      d.di = 2'd1;
      r = r - 5'd9;
    end else begin
      d.di = 2'd0;
    end
    if (r >= 5'd6) begin
      d.dj = 2'd2;
      r = r - 5'd6;
    end else if (r >= 5'd3) begin
      d.dj = 2'd1;
      r = r - 5'd3;
    end else begin
      d.dj = 2'd0;
    end
    d.dk = r[1:0];
    return d;
  endfunction

  // stencil offset of a batch under the order mode; all three terms share it
  function automatic logic [4:0] map_off(input logic [4:0] batch, input logic [1:0] mode);
    logic [4:0] off;
    if (mode == MODE_CENTRE) begin
      if (batch == 5'd0) begin
        off = 5'(CENTRE_OFF);
      end else if (batch <= 5'(CENTRE_OFF)) begin
        off = batch - 5'd1;
      end else begin
        off = batch;
      end
    end else if (mode == MODE_REV) begin
      off = 5'(NUM_OFFS - 1) - batch;
    end else begin
      off = batch;
    end
    return off;
  endfunction

  // representative component pair of a corner read type
  function automatic rep_comp_t rep_comp(input logic [1:0] rtype, input digits_t d);
    rep_comp_t r;
    logic      s0;
    logic      s1;
    logic      s2;
    logic      want_eq;
    s0 = (d.di == 2'd2);
    s1 = (d.dj == 2'd2);
    s2 = (d.dk == 2'd2);
    want_eq = (rtype == 2'd2);
    r.in_c = 2'd0;
    r.out_c = 2'd0;
    if (rtype != 2'd1) begin
      if ((s0 == s1) == want_eq) begin
        r.out_c = 2'd1;
      end else if ((s0 == s2) == want_eq) begin
        r.out_c = 2'd2;
      end else if (want_eq) begin
        r.in_c = 2'd1;
        r.out_c = 2'd2;
      end
    end
    return r;
  endfunction

endpackage

// ===== hw/rtl/strag_in_if.sv =====
// ----------------------------------------------------------------------------
// strag_in_if
// Batch request channel: group slot and stream batch.
// ----------------------------------------------------------------------------
interface strag_in_if;
  logic                               valid;
  logic                               ready;
  logic [strag_pkg::GSLOT_W-1:0]      buf_slot;
  logic [strag_pkg::BATCH_W-1:0]      batch_sel;

  modport source (output valid, output buf_slot, output batch_sel, input ready);
  modport sink (input valid, input buf_slot, input batch_sel, output ready);
endinterface

// ===== hw/rtl/strag_out_if.sv =====
// ----------------------------------------------------------------------------
// strag_out_if
// Descriptor channel: coefficient page reads and B tile descriptors.
// ----------------------------------------------------------------------------
interface strag_out_if;
  logic                          valid;
  logic                          ready;
  logic                          kind;
  logic [1:0]                    split;
  logic [strag_pkg::PAGE_W-1:0]  page;
  logic [strag_pkg::DEST_W-1:0]  dest_slot;
  logic [strag_pkg::HALO_W-1:0]  halo_offset;
  logic                          last;

  modport source (output valid, output kind, output split, output page,
                  output dest_slot, output halo_offset, output last, input ready);
  modport sink (input valid, input kind, input split, input page,
                input dest_slot, input halo_offset, input last, output ready);
endinterface

// ===== hw/rtl/strag_ctrl.sv =====
// ----------------------------------------------------------------------------
// strag_ctrl
// Sequencer: walks the descriptor order of one batch, one beat per cycle unless the output stalls.
// ----------------------------------------------------------------------------
module strag_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                out_ready,
  output logic                out_valid,
  input  strag_pkg::status_t  status,
  output strag_pkg::cmd_t     cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_GRP,
    S_BASE,
    S_CORNER,
    S_READ,
    S_BDESC
  } state_t;

  state_t     state;
  logic [1:0] cnt_lane;
  logic [1:0] cnt_outer;
  logic [1:0] cnt_inner;
  logic       corner_q;
  logic       emit_ok;
  logic       emit;

  assign in_ready = (state == S_IDLE);
  assign emit_ok  = !out_valid || out_ready;
  assign emit     = emit_ok &&
                    (state == S_CORNER || state == S_READ || state == S_BDESC);

  always_comb begin
    cmd.load        = in_ready && in_valid;
    cmd.calc_grp    = (state == S_GRP);
    cmd.calc_base   = (state == S_BASE);
    cmd.emit        = emit;
    cmd.sel_b       = (state == S_BDESC);
    cmd.corner_mode = (state == S_CORNER);
    cmd.lane        = cnt_lane;
    cmd.outer       = cnt_outer;
    cmd.inner       = cnt_inner;
    cmd.last        = (state == S_BDESC) && (cnt_lane == 2'd2);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt_lane  <= 2'd0;
      cnt_outer <= 2'd0;
      cnt_inner <= 2'd0;
      corner_q  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            state <= S_GRP;
          end
        end
        S_GRP: begin
          state <= S_BASE;
        end
        S_BASE: begin
          corner_q  <= status.corner;
          cnt_lane  <= 2'd0;
          cnt_outer <= 2'd0;
          cnt_inner <= 2'd0;
          state     <= status.corner ? S_CORNER : S_READ;
        end
        S_CORNER, S_READ: begin
          // nine reads: outer index slow, split fast
          if (emit) begin
            if (cnt_inner == 2'd2) begin
              cnt_inner <= 2'd0;
              if (cnt_outer == 2'd2) begin
                cnt_outer <= 2'd0;
                state     <= S_BDESC;
              end else begin
                cnt_outer <= cnt_outer + 2'd1;
              end
            end else begin
              cnt_inner <= cnt_inner + 2'd1;
            end
          end
        end
        S_BDESC: begin
          if (emit) begin
            if (cnt_lane == 2'd2) begin
              cnt_lane <= 2'd0;
              state    <= S_IDLE;
            end else begin
              cnt_lane <= cnt_lane + 2'd1;
              state    <= corner_q ? S_BDESC : S_READ;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== hw/rtl/strag_dp.sv =====
// ----------------------------------------------------------------------------
// strag_dp
// Datapath: batch decode, page and halo offset arithmetic, output register.
// ----------------------------------------------------------------------------
module strag_dp #(
  parameter int unsigned GROUP_SLOTS = 16
) (
  input  logic                              clk,
  input  strag_pkg::cmd_t                   cmd,
  output strag_pkg::status_t                status,
  input  logic [1:0]                        term_order,
  input  logic [strag_pkg::CFG_W-1:0]       base_group,
  input  logic [strag_pkg::GSLOT_W-1:0]     buf_slot,
  input  logic [strag_pkg::BATCH_W-1:0]     batch_sel,
  output logic                              kind,
  output logic [1:0]                        split,
  output logic [strag_pkg::PAGE_W-1:0]      page,
  output logic [strag_pkg::DEST_W-1:0]      dest_slot,
  output logic [strag_pkg::HALO_W-1:0]      halo_offset,
  output logic                              last
);

  localparam int unsigned SLOT_W = (GROUP_SLOTS > 1) ? $clog2(GROUP_SLOTS) : 1;
  localparam int unsigned GRP_W  = strag_pkg::CFG_W + 1;
  localparam int unsigned PW     = strag_pkg::PAGE_W;
  localparam int unsigned HW     = strag_pkg::HALO_W;

  logic [SLOT_W-1:0]  slot_mod;
  logic [4:0]         batch_fold;
  logic [SLOT_W-1:0]  slot_q;
  logic [4:0]         batch_q;
  logic [GRP_W-1:0]   grp_q;
  logic [4:0]         off_q;
  logic               rev_q;
  logic [PW-1:0]      base_q;

  strag_pkg::digits_t    dig;
  strag_pkg::rep_comp_t  rc;
  logic [1:0]            comp;
  logic [6:0]            term;
  logic [6:0]            x_sel;
  logic [1:0]            oc_sel;
  logic [PW-1:0]         sum;
  logic [PW-1:0]         page_a;
  logic [4:0]            dest_a;
  logic [HW-1:0]         halo_b;

  // slot modulo the buffer depth, one constant entry per input code
  always_comb begin
    slot_mod = '0;
    for (int i = 0; i < (1 << strag_pkg::GSLOT_W); i++) begin
      if (buf_slot == strag_pkg::GSLOT_W'(i)) begin
        slot_mod = SLOT_W'(i % GROUP_SLOTS);
      end
    end
  end

  // batches past the last wrap back once
  assign batch_fold = (batch_sel >= 5'(strag_pkg::NUM_OFFS)) ?
                      batch_sel - 5'(strag_pkg::NUM_OFFS) : batch_sel;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      slot_q  <= slot_mod;
      batch_q <= batch_fold;
    end
    if (cmd.calc_grp) begin
      grp_q <= GRP_W'(base_group) + GRP_W'(slot_q);
      off_q <= strag_pkg::map_off(batch_q, term_order);
      rev_q <= (term_order == strag_pkg::MODE_REV);
    end
    if (cmd.calc_base) begin
      base_q <= PW'(grp_q) * PW'(strag_pkg::NUM_TERMS);
    end
  end

  assign dig = strag_pkg::off_digits(off_q);
  assign status.corner = (dig.di != 2'd1) && (dig.dj != 2'd1) && (dig.dk != 2'd1);

  assign rc   = strag_pkg::rep_comp(cmd.outer, dig);
  assign comp = rev_q ? (2'd2 - cmd.lane) : cmd.lane;
  assign term = 7'(off_q) * 7'd3 + 7'(comp);

  always_comb begin
    if (cmd.corner_mode) begin
      x_sel  = 7'(off_q) * 7'd3 + 7'(rc.in_c);
      oc_sel = rc.out_c;
      dest_a = 5'(cmd.inner) * 5'd3 + 5'(cmd.outer);
    end else begin
      x_sel  = term;
      oc_sel = cmd.outer;
      dest_a = 5'(cmd.lane) * 5'd9 + 5'(cmd.inner) * 5'd3 + 5'(cmd.outer);
    end
  end

  assign sum    = base_q + PW'(x_sel);
  assign page_a = (sum << 1) + sum + PW'(oc_sel);

  // word offset: plane of (slot, comp) plus 18*di + 3*dj + dk
  assign halo_b = ((HW'(slot_q) * HW'(9) + HW'(comp) * HW'(3)) << strag_pkg::PLANE_SHIFT)
                  + HW'(off_q) + HW'(dig.di) * HW'(9);

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      last <= cmd.last;
      if (cmd.sel_b) begin
        kind        <= strag_pkg::KIND_B;
        split       <= 2'd0;
        page        <= '0;
        dest_slot   <= 5'(cmd.lane);
        halo_offset <= halo_b;
      end else begin
        kind        <= strag_pkg::KIND_A;
        split       <= cmd.inner;
        page        <= page_a;
        dest_slot   <= dest_a;
        halo_offset <= '0;
      end
    end
  end

endmodule

// ===== hw/rtl/stencil_tile_read_address_gen_unit.sv =====
// first beat: the request is registered, S_GRP forms the group, S_BASE the page base,
//   and S_CORNER or S_READ loads it into the single output register; then one beat
//   per cycle unless the output stalls; a corner batch gives 12 beats, any other 30;
// a new request is taken once the last beat of the batch is in the output register
// reset (rst, synchronous): sequencer idle, output empty, both config registers cleared
// ----------------------------------------------------------------------------
// stencil_tile_read_address_gen_unit
// Turns a (group slot, stream batch) request into coefficient page reads and
// B tile descriptors, ordered by the configured term order.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module stencil_tile_read_address_gen_unit #(
  parameter int unsigned GROUP_SLOTS = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                wr_en,
  input  logic [strag_pkg::CFG_IDX_W-1:0]     wr_index,
  input  logic [strag_pkg::CFG_W-1:0]         wr_data,
  strag_in_if.sink                            in_ch,
  strag_out_if.source                         out_ch
);

  logic [1:0]                    term_order;
  logic [strag_pkg::CFG_W-1:0]   base_group;
  strag_pkg::cmd_t               cmd;
  strag_pkg::status_t            status;
  logic                          req_beat;
  logic                          field_zero_ok;

  always_ff @(posedge clk) begin
    if (rst) begin
      term_order <= 2'd0;
      base_group <= '0;
    end else if (wr_en) begin
      unique case (wr_index)
        strag_pkg::CFG_TERM_ORDER: term_order <= wr_data[1:0];
        strag_pkg::CFG_BASE_GROUP: base_group <= wr_data;
        default: ;
      endcase
    end
  end

  strag_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_ready (out_ch.ready),
    .out_valid (out_ch.valid),
    .status    (status),
    .cmd       (cmd)
  );

  strag_dp #(
    .GROUP_SLOTS (GROUP_SLOTS)
  ) u_dp (
    .clk          (clk),
    .cmd          (cmd),
    .status       (status),
    .term_order   (term_order),
    .base_group   (base_group),
    .buf_slot     (in_ch.buf_slot),
    .batch_sel    (in_ch.batch_sel),
    .kind         (out_ch.kind),
    .split        (out_ch.split),
    .page         (out_ch.page),
    .dest_slot    (out_ch.dest_slot),
    .halo_offset  (out_ch.halo_offset),
    .last         (out_ch.last)
  );

  assign req_beat = in_ch.valid && in_ch.ready;
  // page reads carry no halo offset, B descriptors no page and no split
  assign field_zero_ok = (out_ch.kind == strag_pkg::KIND_A) ? (out_ch.halo_offset == '0) :
                         (out_ch.page == '0 && out_ch.split == 2'd0);

  // one batch in flight: no request is taken right after another
  `ASSERT_CLK(a_one_batch, req_beat |=> !in_ch.ready, "request taken while busy")
  // a batch always closes on a B tile descriptor
  `ASSERT_CLK(a_last_is_b, (out_ch.valid && out_ch.last) |-> out_ch.kind, "batch closed on a read")
  `ASSERT_CLK(a_field_zero, out_ch.valid |-> field_zero_ok, "unused descriptor field not zero")

endmodule

// ===== bench/stencil_tile_read_address_gen_unit_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stencil_tile_read_address_gen_unit_test
// Drives batch requests into the address generator, predicts every descriptor
// beat from the configured term order and start group, and compares each beat
// on the descriptor channel field by field, under random stalls on both sides.
// ----------------------------------------------------------------------------
module stencil_tile_read_address_gen_unit_test;

  localparam int unsigned CENTRE_TERM = 39;
  localparam int unsigned PAGE_MASK = 24'hFFFFFF;
  localparam int unsigned HALO_MASK = 20'hFFFFF;
  localparam logic [1:0] MODE_NATURAL = 2'd0;
  localparam logic [1:0] MODE_SPARE = 2'd3;
  localparam int RAND_PHASES = 8;
  localparam int PHASE_ITEMS = 55;
  localparam int HOLD_CYCLES = 300;
  localparam longint LIMIT_NS = 5_000_000;

  typedef struct packed {
    logic                         kind;
    logic [1:0]                   split;
    logic [strag_pkg::PAGE_W-1:0] page;
    logic [strag_pkg::DEST_W-1:0] dest_slot;
    logic [strag_pkg::HALO_W-1:0] halo_offset;
    logic                         last;
  } desc_t;

  typedef struct packed {
    logic                            is_cfg;
    logic [strag_pkg::CFG_IDX_W-1:0] reg_idx;
    logic [strag_pkg::CFG_W-1:0]     value;
    logic [strag_pkg::GSLOT_W-1:0]   slot;
    logic [strag_pkg::BATCH_W-1:0]   batch;
    logic                            typed;
    desc_t                           first;
  } stim_row_t;

  logic                            clk;
  logic                            rst;
  logic                            wr_en;
  logic [strag_pkg::CFG_IDX_W-1:0] wr_index;
  logic [strag_pkg::CFG_W-1:0]     wr_data;

  strag_in_if  in_ch();
  strag_out_if out_ch();

  stencil_tile_read_address_gen_unit #(
    .GROUP_SLOTS(16)
  ) uut (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data),
    .in_ch    (in_ch),
    .out_ch   (out_ch)
  );

  // predictor copy of the registers
  logic [1:0]                  cur_mode;
  logic [strag_pkg::CFG_W-1:0] cur_base_group;

  desc_t     pending_desc[$];
  stim_row_t stim_rows[$];
  int        failures;
  logic      steady;
  int        hold_reqs;

  initial begin
    clk = 1'b0;
  end

  always #5 clk = ~clk;

  initial begin
    #(LIMIT_NS);
    $display("Regression FAIL");
    $finish;
  end

  function automatic int unsigned order_term(input int unsigned st, input logic [1:0] mode);
    int unsigned t;
    t = st;
    if (mode == strag_pkg::MODE_CENTRE) begin
      if (t < 3) return CENTRE_TERM + t;
      t = t - 3;
      return (t < CENTRE_TERM) ? t : t + 3;
    end
    if (mode == strag_pkg::MODE_REV) return strag_pkg::NUM_TERMS - 1 - t;
    return t;
  endfunction

  // corner: no base-3 digit of the offset is the middle one
  function automatic bit corner_off(input int unsigned off);
    return (off / 9 != 1) && ((off / 3) % 3 != 1) && (off % 3 != 1);
  endfunction

  function automatic int unsigned corner_page(input int unsigned grp, input int unsigned off,
                                              input int unsigned rtype);
    int unsigned in_c;
    int unsigned out_c;
    bit          hi_i;
    bit          hi_j;
    bit          hi_k;
    bit          same;
    in_c = 0;
    out_c = 0;
    hi_i = (off / 9) == 2;
    hi_j = ((off / 3) % 3) == 2;
    hi_k = (off % 3) == 2;
    same = (rtype == 2);
    if (rtype != 1) begin
      if ((hi_i == hi_j) == same) begin
        out_c = 1;
      end else if ((hi_i == hi_k) == same) begin
        out_c = 2;
      end else if (same) begin
        in_c = 1;
        out_c = 2;
      end
    end
    return ((grp * strag_pkg::NUM_TERMS + off * 3 + in_c) * 3 + out_c) & PAGE_MASK;
  endfunction

  function automatic desc_t make_desc(input logic kind, input int unsigned split,
                                      input int unsigned page, input int unsigned dest,
                                      input int unsigned halo);
    desc_t d;
    d.kind = kind;
    d.split = split[1:0];
    d.page = page[strag_pkg::PAGE_W-1:0];
    d.dest_slot = dest[strag_pkg::DEST_W-1:0];
    d.halo_offset = halo[strag_pkg::HALO_W-1:0];
    d.last = 1'b0;
    return d;
  endfunction

  // all descriptor beats of one batch request, queued in channel order
  function automatic void expand_batch(input logic [strag_pkg::GSLOT_W-1:0] slot,
                                       input logic [strag_pkg::BATCH_W-1:0] sb,
                                       input logic typed, input desc_t typed_first);
    desc_t       beats[30];
    int          n;
    int unsigned b;
    int unsigned grp;
    int unsigned first_off;
    int unsigned term;
    int unsigned off;
    int unsigned comp;
    int unsigned pg;
    int unsigned halo;
    bit          corner;
    n = 0;
    b = sb;
    if (b >= strag_pkg::NUM_OFFS) b = b - strag_pkg::NUM_OFFS;
    grp = int'(cur_base_group) + int'(slot);
    first_off = order_term(b * 3, cur_mode) / 3;
    corner = corner_off(first_off);
    if (corner) begin
      for (int t = 0; t < 3; t++) begin
        pg = corner_page(grp, first_off, t);
        for (int s = 0; s < 3; s++) begin
          beats[n] = make_desc(strag_pkg::KIND_A, s, pg, s * 3 + t, 0);
          n++;
        end
      end
    end
    for (int lane = 0; lane < 3; lane++) begin
      term = order_term(b * 3 + lane, cur_mode);
      off = term / 3;
      comp = term % 3;
      if (!corner) begin
        for (int oc = 0; oc < 3; oc++) begin
          pg = ((grp * strag_pkg::NUM_TERMS + term) * 3 + oc) & PAGE_MASK;
          for (int s = 0; s < 3; s++) begin
            beats[n] = make_desc(strag_pkg::KIND_A, s, pg, lane * 9 + s * 3 + oc, 0);
            n++;
          end
        end
      end
      halo = ((int'(slot) * 9 + comp * 3) * strag_pkg::PLANE_WORDS
              + ((off / 9) * 6 + (off / 3) % 3) * 3 + off % 3) & HALO_MASK;
      beats[n] = make_desc(strag_pkg::KIND_B, 0, 0, lane, halo);
      n++;
    end
    beats[n-1].last = 1'b1;
    if (typed) beats[0] = typed_first;
    for (int i = 0; i < n; i++) pending_desc.push_back(beats[i]);
  endfunction

  function automatic void add_item(input int unsigned slot, input int unsigned batch);
    stim_row_t r;
    r = '0;
    r.slot = slot[strag_pkg::GSLOT_W-1:0];
    r.batch = batch[strag_pkg::BATCH_W-1:0];
    stim_rows.push_back(r);
  endfunction

  function automatic void add_typed(input int unsigned slot, input int unsigned batch,
                                    input desc_t first);
    stim_row_t r;
    r = '0;
    r.slot = slot[strag_pkg::GSLOT_W-1:0];
    r.batch = batch[strag_pkg::BATCH_W-1:0];
    r.typed = 1'b1;
    r.first = first;
    stim_rows.push_back(r);
  endfunction

  function automatic void add_cfg(input logic [strag_pkg::CFG_IDX_W-1:0] idx,
                                  input int unsigned value);
    stim_row_t r;
    r = '0;
    r.is_cfg = 1'b1;
    r.reg_idx = idx;
    r.value = value[strag_pkg::CFG_W-1:0];
    stim_rows.push_back(r);
  endfunction

  task automatic send_batch(input logic [strag_pkg::GSLOT_W-1:0] slot,
                            input logic [strag_pkg::BATCH_W-1:0] batch,
                            input logic typed, input desc_t typed_first);
    while (!steady && $urandom_range(99) < 15) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.buf_slot <= slot;
    in_ch.batch_sel <= batch;
    do @(posedge clk); while (!in_ch.ready);
    expand_batch(slot, batch, typed, typed_first);
  endtask

  // stop offering and let every outstanding beat come out
  task automatic drain();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (pending_desc.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [strag_pkg::CFG_IDX_W-1:0] idx,
                           input logic [strag_pkg::CFG_W-1:0] value);
    wr_en <= 1'b1;
    wr_index <= idx;
    wr_data <= value;
    @(posedge clk);
    wr_en <= 1'b0;
    if (idx == strag_pkg::CFG_TERM_ORDER) begin
      cur_mode = value[1:0];
    end else begin
      cur_base_group = value;
    end
    @(posedge clk);
  endtask

  task automatic check_field(input string name, input int unsigned want, input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      failures++;
    end
  endtask

  // descriptor sink: random stalls plus one long hold-off on request
  int hold_seen = 0;
  int hold_cnt = 0;

  always @(posedge clk) begin
    if (hold_reqs != hold_seen) begin
      hold_seen = hold_reqs;
      hold_cnt = HOLD_CYCLES;
    end
    if (hold_cnt > 0) begin
      hold_cnt--;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= steady || ($urandom_range(99) >= 15);
    end
  end

  always @(posedge clk) begin
    desc_t want;
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (pending_desc.size() == 0) begin
        $error("unexpected beat: kind %0d page %0d dest_slot %0d",
               out_ch.kind, out_ch.page, out_ch.dest_slot);
        failures++;
      end else begin
        want = pending_desc.pop_front();
        check_field("kind", want.kind, out_ch.kind);
        check_field("split", want.split, out_ch.split);
        check_field("page", want.page, out_ch.page);
        check_field("dest_slot", want.dest_slot, out_ch.dest_slot);
        check_field("halo_offset", want.halo_offset, out_ch.halo_offset);
        check_field("last", want.last, out_ch.last);
      end
    end
  end

  initial begin
    stim_row_t   row;
    logic [1:0]  mode;
    int unsigned group_base;
    int unsigned batch;
    rst = 1'b1;
    wr_en = 1'b0;
    wr_index = strag_pkg::CFG_TERM_ORDER;
    wr_data = '0;
    in_ch.valid = 1'b0;
    in_ch.buf_slot = '0;
    in_ch.batch_sel = '0;
    out_ch.ready = 1'b0;
    failures = 0;
    steady = 1'b0;
    hold_reqs = 0;
    cur_mode = MODE_NATURAL;
    cur_base_group = '0;

    // registers at reset values
    add_typed(0, 0, make_desc(strag_pkg::KIND_A, 0, 0, 0, 0));
    add_typed(0, 13, make_desc(strag_pkg::KIND_A, 0, 117, 0, 0));
    add_item(15, 26);
    add_item(10, 27);
    add_item(5, 31);
    add_item(3, 14);
    add_cfg(strag_pkg::CFG_TERM_ORDER, strag_pkg::MODE_CENTRE);
    add_item(0, 0);
    add_item(1, 4);
    add_item(2, 5);
    add_item(6, 13);
    add_item(7, 26);
    add_cfg(strag_pkg::CFG_TERM_ORDER, strag_pkg::MODE_REV);
    add_typed(0, 0, make_desc(strag_pkg::KIND_A, 0, 234, 0, 0));
    add_item(9, 13);
    add_item(12, 26);
    add_item(4, 29);
    add_cfg(strag_pkg::CFG_TERM_ORDER, MODE_SPARE);
    add_item(8, 2);
    add_item(11, 20);
    add_cfg(strag_pkg::CFG_TERM_ORDER, MODE_NATURAL);
    add_cfg(strag_pkg::CFG_BASE_GROUP, 65520);
    add_typed(15, 26, make_desc(strag_pkg::KIND_A, 0, 15925239, 0, 0));
    add_item(0, 0);
    add_item(14, 17);
    add_cfg(strag_pkg::CFG_BASE_GROUP, 65535);
    add_cfg(strag_pkg::CFG_TERM_ORDER, strag_pkg::MODE_CENTRE);
    add_item(15, 0);
    add_item(15, 30);

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (stim_rows[i]) begin
      row = stim_rows[i];
      if (row.is_cfg) begin
        drain();
        write_reg(row.reg_idx, row.value);
      end else begin
        send_batch(row.slot, row.batch, row.typed, row.first);
      end
    end

    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      drain();
      mode = (ph < 4) ? 2'(ph) : 2'($urandom_range(3));
      case (ph % 4)
        0: group_base = 0;
        1: group_base = 65520;
        2: group_base = 65535;
        default: group_base = $urandom_range(65535);
      endcase
      write_reg(strag_pkg::CFG_TERM_ORDER, strag_pkg::CFG_W'(mode));
      write_reg(strag_pkg::CFG_BASE_GROUP, strag_pkg::CFG_W'(group_base));
      steady <= (ph == 3);
      if (ph == 1) hold_reqs <= hold_reqs + 1;
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (ph == 5 && i == PHASE_ITEMS / 2) drain();
        // out-of-range batches now and then
        if ($urandom_range(9) == 0) begin
          batch = strag_pkg::NUM_OFFS + $urandom_range(4);
        end else begin
          batch = $urandom_range(strag_pkg::NUM_OFFS - 1);
        end
        send_batch(strag_pkg::GSLOT_W'($urandom_range(15)), strag_pkg::BATCH_W'(batch),
                   1'b0, '0);
      end
    end

    in_ch.valid <= 1'b0;
    while (pending_desc.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (failures == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
